// ===== design/rgblab_pkg.sv =====
package rgblab_pkg;

  // Fixed-point format of the normalized XYZ values and of their cube roots.
  localparam int FRAC_BITS = 16;
  localparam int ROOT_BITS = 10;

  localparam int CH_W      = 8;
  localparam int NUM_LANES = 3;
  localparam int LANE_X    = 0;
  localparam int LANE_Y    = 1;
  localparam int LANE_Z    = 2;

  localparam int          XQ_W = FRAC_BITS + 1;
  localparam int unsigned ONE  = 1 << FRAC_BITS;

  // Matrix rows in millionths, and the divisors 255 * white * 10^6.
  localparam int COEF_W  = 20;
  localparam int SUM_W   = 29;
  localparam int DEN_W   = 29;
  localparam int RECIP_W = FRAC_BITS + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int CMP_W   = FRAC_BITS + DEN_W + 2;

  localparam logic [COEF_W-1:0] COEF [NUM_LANES][NUM_LANES] = '{
    '{20'd412453, 20'd357580, 20'd180423},
    '{20'd212671, 20'd715160, 20'd72169},
    '{20'd19334,  20'd119193, 20'd950227}
  };

  localparam longint unsigned DEN_X = 64'd242369850;
  localparam longint unsigned DEN_Y = 64'd255000000;
  localparam longint unsigned DEN_Z = 64'd277651650;

  localparam longint unsigned DEN [NUM_LANES] = '{DEN_X, DEN_Y, DEN_Z};

  // The estimate sum * RECIP >> SUM_W is low by at most one.
  localparam longint unsigned RECIP [NUM_LANES] = '{
    (64'd1 << (FRAC_BITS + SUM_W)) / DEN_X,
    (64'd1 << (FRAC_BITS + SUM_W)) / DEN_Y,
    (64'd1 << (FRAC_BITS + SUM_W)) / DEN_Z
  };

  // Cube root table and interpolation.
  localparam int TABLE_LEN = (1 << ROOT_BITS) + 1;
  localparam int IDX_W     = ROOT_BITS + 1;
  localparam int INTERP_SH = (FRAC_BITS >= ROOT_BITS) ? FRAC_BITS - ROOT_BITS : 0;
  localparam int IDX_LSH   = (FRAC_BITS >= ROOT_BITS) ? 0 : ROOT_BITS - FRAC_BITS;
  localparam int FRAC_W    = (INTERP_SH > 0) ? INTERP_SH : 1;
  localparam int FRAC_MASK = (1 << INTERP_SH) - 1;
  localparam int IDX_SRC_W = XQ_W + IDX_LSH;
  localparam int IPROD_W   = XQ_W + FRAC_W;
  localparam int CUBE_W    = 3 * FRAC_BITS + 2;

  // Output arithmetic: L uses 51 * (116 * cy - 16) over 20, as a shift by two, then a divide by five.
  localparam int L_MUL     = 5916;
  localparam int L_OFS     = 816;
  localparam int L_W       = FRAC_BITS + 14;
  localparam int LQ_W      = 12;
  localparam int DIV5_MUL  = 13108;
  localparam int DIV5_SH   = 16;
  localparam int DIV5_W    = LQ_W + 14;
  localparam int AB_W      = FRAC_BITS + 11;
  localparam int A_MUL     = 500;
  localparam int B_MUL     = 200;
  localparam int AB_OFS    = 128;
  localparam int BYTE_MAX  = 255;

  // Pipeline stages, in order.
  localparam int NUM_STAGES    = 9;
  localparam int ST_MATRIX     = 0;
  localparam int ST_RECIP      = 1;
  localparam int ST_CHECK      = 2;
  localparam int ST_FIX        = 3;
  localparam int ST_ROM        = 4;
  localparam int ST_INTERP_MUL = 5;
  localparam int ST_INTERP_ADD = 6;
  localparam int ST_LAB        = 7;
  localparam int ST_OUT        = 8;

  typedef logic [XQ_W-1:0]       xq_t;
  typedef logic [NUM_STAGES-1:0] stage_en_t;
  typedef logic [XQ_W-1:0]       root_rom_t [TABLE_LEN];

  // Entry i is floor(cbrt(i / 2^ROOT_BITS)) in Q.FRAC_BITS, found by bisection.
  function automatic root_rom_t build_root_rom();
    root_rom_t         rom;
    logic [CUBE_W-1:0] target;
    logic [CUBE_W-1:0] mid3;
    logic [XQ_W:0]     lo;
    logic [XQ_W:0]     hi;
    logic [XQ_W:0]     mid;
    for (int i = 0; i < TABLE_LEN; i++) begin
      target = CUBE_W'(i) << (3 * FRAC_BITS - ROOT_BITS);
      lo = '0;
      hi = (XQ_W + 1)'(ONE);
      while (lo < hi) begin
        mid  = lo + ((hi - lo + (XQ_W + 1)'(1)) >> 1);
        mid3 = CUBE_W'(mid) * CUBE_W'(mid) * CUBE_W'(mid);
        if (mid3 <= target) begin
          lo = mid;
        end else begin
          hi = mid - (XQ_W + 1)'(1);
        end
      end
      rom[i] = XQ_W'(lo);
    end
    return rom;
  endfunction

  localparam root_rom_t ROOT_ROM = build_root_rom();

endpackage

// ===== design/rgblab_ifs.sv =====
interface rgblab_rgb_if import rgblab_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgblab_lab_if import rgblab_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] lightness;
  logic [CH_W-1:0] green_red;
  logic [CH_W-1:0] blue_yellow;

  modport source (output valid, lightness, green_red, blue_yellow, input ready);
  modport sink (input valid, lightness, green_red, blue_yellow, output ready);
endinterface

// ===== design/rgblab_xyz.sv =====
module rgblab_xyz import rgblab_pkg::*; (
  input  logic            clk_i,
  input  stage_en_t       en_i,
  input  logic [CH_W-1:0] red_i,
  input  logic [CH_W-1:0] green_i,
  input  logic [CH_W-1:0] blue_i,
  output xq_t             xyz_o [NUM_LANES]
);

  logic [SUM_W-1:0]   sum_d  [NUM_LANES];
  logic [SUM_W-1:0]   sum1_q [NUM_LANES];
  logic [SUM_W-1:0]   sum2_q [NUM_LANES];
  logic [SUM_W-1:0]   sum3_q [NUM_LANES];
  logic [RECIP_W-1:0] est_d  [NUM_LANES];
  logic [RECIP_W-1:0] est2_q [NUM_LANES];
  logic [RECIP_W-1:0] est3_q [NUM_LANES];
  logic [CMP_W-1:0]   lim_d  [NUM_LANES];
  logic [CMP_W-1:0]   lim3_q [NUM_LANES];
  logic [XQ_W:0]      cand   [NUM_LANES];
  xq_t                xyz_d  [NUM_LANES];
  xq_t                xyz_q  [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      sum_d[l] = SUM_W'(COEF[l][0]) * SUM_W'(red_i)
               + SUM_W'(COEF[l][1]) * SUM_W'(green_i)
               + SUM_W'(COEF[l][2]) * SUM_W'(blue_i);

      est_d[l] = RECIP_W'((PROD_W'(sum1_q[l]) * PROD_W'(RECIP[l])) >> SUM_W);

      // Bound of the next quotient step: (estimate + 1) * divisor.
      lim_d[l] = (CMP_W'(est2_q[l]) + CMP_W'(1)) * CMP_W'(DEN[l]);

      if ((CMP_W'(sum3_q[l]) << FRAC_BITS) >= lim3_q[l]) begin
        cand[l] = (XQ_W + 1)'(est3_q[l]) + (XQ_W + 1)'(1);
      end else begin
        cand[l] = (XQ_W + 1)'(est3_q[l]);
      end

      if (cand[l] > (XQ_W + 1)'(ONE)) begin
        xyz_d[l] = XQ_W'(ONE);
      end else begin
        xyz_d[l] = XQ_W'(cand[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_MATRIX]) begin
      sum1_q <= sum_d;
    end
    if (en_i[ST_RECIP]) begin
      sum2_q <= sum1_q;
      est2_q <= est_d;
    end
    if (en_i[ST_CHECK]) begin
      sum3_q <= sum2_q;
      est3_q <= est2_q;
      lim3_q <= lim_d;
    end
    if (en_i[ST_FIX]) begin
      xyz_q <= xyz_d;
    end
  end

  assign xyz_o = xyz_q;

endmodule

// ===== design/rgblab_root.sv =====
module rgblab_root import rgblab_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  xq_t       x_i,
  output xq_t       root_o
);

  logic [IDX_SRC_W-1:0] x_sh;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     idx_nx;
  logic [FRAC_W-1:0]    frac_d;
  logic [FRAC_W-1:0]    frac_q;
  xq_t                  y0_q;
  xq_t                  y1_q;
  xq_t                  base_q;
  logic [IPROD_W-1:0]   prod_d;
  logic [IPROD_W-1:0]   prod_q;
  xq_t                  root_d;
  xq_t                  root_q;

  always_comb begin
    x_sh   = IDX_SRC_W'(x_i) << IDX_LSH;
    idx    = IDX_W'(x_sh >> INTERP_SH);
    // The top entry has no right neighbor and interpolates against itself.
    idx_nx = (idx == IDX_W'(TABLE_LEN - 1)) ? idx : idx + IDX_W'(1);
    frac_d = FRAC_W'(x_i & XQ_W'(FRAC_MASK));
    prod_d = IPROD_W'(y1_q - y0_q) * IPROD_W'(frac_q);
    root_d = base_q + XQ_W'(prod_q >> INTERP_SH);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_ROM]) begin
      y0_q   <= ROOT_ROM[idx];
      y1_q   <= ROOT_ROM[idx_nx];
      frac_q <= frac_d;
    end
    if (en_i[ST_INTERP_MUL]) begin
      base_q <= y0_q;
      prod_q <= prod_d;
    end
    if (en_i[ST_INTERP_ADD]) begin
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

// ===== design/rgblab_out.sv =====
module rgblab_out import rgblab_pkg::*; (
  input  logic            clk_i,
  input  stage_en_t       en_i,
  input  xq_t             root_i [NUM_LANES],
  output logic [CH_W-1:0] lightness_o,
  output logic [CH_W-1:0] green_red_o,
  output logic [CH_W-1:0] blue_yellow_o
);

  // Truncates (pos - neg) / 2^FRAC_BITS to a byte, zero when negative and 255 when above.
  function automatic logic [CH_W-1:0] sat_byte(input logic [AB_W-1:0] pos,
                                               input logic [AB_W-1:0] neg);
    logic [AB_W-1:0]           diff;
    logic [AB_W-FRAC_BITS-1:0] whole;
    diff  = pos - neg;
    whole = (AB_W - FRAC_BITS)'(diff >> FRAC_BITS);
    if (pos < neg) begin
      return '0;
    end else if (whole > (AB_W - FRAC_BITS)'(BYTE_MAX)) begin
      return CH_W'(BYTE_MAX);
    end
    return CH_W'(whole);
  endfunction

  logic [L_W-1:0]    lp;
  logic [L_W-1:0]    lo;
  logic [LQ_W-1:0]   lw_d;
  logic [LQ_W-1:0]   lw_q;
  logic [AB_W-1:0]   a_pos;
  logic [AB_W-1:0]   a_neg;
  logic [AB_W-1:0]   b_pos;
  logic [AB_W-1:0]   b_neg;
  logic [CH_W-1:0]   a_d;
  logic [CH_W-1:0]   b_d;
  logic [CH_W-1:0]   a_q;
  logic [CH_W-1:0]   b_q;
  logic [DIV5_W-1:0] lq;
  logic [CH_W-1:0]   l_d;
  logic [CH_W-1:0]   l_out_q;
  logic [CH_W-1:0]   a_out_q;
  logic [CH_W-1:0]   b_out_q;

  always_comb begin
    lp   = L_W'(L_MUL) * L_W'(root_i[LANE_Y]);
    lo   = L_W'(L_OFS) << FRAC_BITS;
    lw_d = (lp < lo) ? '0 : LQ_W'((lp - lo) >> (FRAC_BITS + 2));

    a_pos = AB_W'(A_MUL) * AB_W'(root_i[LANE_X]) + (AB_W'(AB_OFS) << FRAC_BITS);
    a_neg = AB_W'(A_MUL) * AB_W'(root_i[LANE_Y]);
    b_pos = AB_W'(B_MUL) * AB_W'(root_i[LANE_Y]) + (AB_W'(AB_OFS) << FRAC_BITS);
    b_neg = AB_W'(B_MUL) * AB_W'(root_i[LANE_Z]);
    a_d   = sat_byte(a_pos, a_neg);
    b_d   = sat_byte(b_pos, b_neg);

    // Divide by five through the reciprocal; exact for this input range.
    lq  = (DIV5_W'(lw_q) * DIV5_W'(DIV5_MUL)) >> DIV5_SH;
    l_d = (lq > DIV5_W'(BYTE_MAX)) ? CH_W'(BYTE_MAX) : CH_W'(lq);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_LAB]) begin
      lw_q <= lw_d;
      a_q  <= a_d;
      b_q  <= b_d;
    end
    if (en_i[ST_OUT]) begin
      l_out_q <= l_d;
      a_out_q <= a_q;
      b_out_q <= b_q;
    end
  end

  assign lightness_o   = l_out_q;
  assign green_red_o   = a_out_q;
  assign blue_yellow_o = b_out_q;

endmodule

// ===== design/rgb8_to_lab8_convert_unit.sv =====
// Throughput: one pixel per cycle while lab_o.ready holds; every stage has its
// own valid bit and a stage loads whenever it is empty or its successor moves,
// so bubbles collapse and input is still taken while the output beat waits, as
// long as some stage is empty.
// Reset clears the valid bits only; the cube root table is a constant ROM.
module rgb8_to_lab8_convert_unit import rgblab_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rgblab_rgb_if.sink   rgb_i,
  rgblab_lab_if.source lab_o
);

  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] valid_q;
  stage_en_t             adv;
  xq_t                   xyz  [NUM_LANES];
  xq_t                   root [NUM_LANES];

  always_comb begin
    adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || lab_o.ready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
    valid_d[0] = adv[0] ? rgb_i.valid : valid_q[0];
    for (int s = 1; s < NUM_STAGES; s++) begin
      valid_d[s] = adv[s] ? valid_q[s-1] : valid_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rgb_i.ready = adv[ST_MATRIX];
  assign lab_o.valid = valid_q[ST_OUT];

  rgblab_xyz u_xyz (
    .clk_i   (clk_i),
    .en_i    (adv),
    .red_i   (rgb_i.red),
    .green_i (rgb_i.green),
    .blue_i  (rgb_i.blue),
    .xyz_o   (xyz)
  );

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_root
    rgblab_root u_root (
      .clk_i  (clk_i),
      .en_i   (adv),
      .x_i    (xyz[l]),
      .root_o (root[l])
    );
  end

  rgblab_out u_out (
    .clk_i         (clk_i),
    .en_i          (adv),
    .root_i        (root),
    .lightness_o   (lab_o.lightness),
    .green_red_o   (lab_o.green_red),
    .blue_yellow_o (lab_o.blue_yellow)
  );

endmodule
